// ===== sv/sep_pkg.sv =====
// shared types, constants and helpers for the sorted edge pwm scheduler
// no dependencies; compiled first
package sep_pkg;

    localparam int CHANNELS   = 16;
    localparam int EDGE_DEPTH = 16;
    localparam int IDX_W      = $clog2(EDGE_DEPTH);
    localparam int CNT_W      = $clog2(EDGE_DEPTH + 1);
    localparam int ADDR_W     = 3;

    // request codes
    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_NEXT  = 2'd2;

    // register index (word address bit of paddr)
    localparam logic REG_PERIOD = 1'b0;

    localparam logic [15:0] PERIOD_RESET = 16'd9856;
    localparam logic [15:0] NO_EDGE      = 16'hFFFF;
    localparam logic [7:0]  FULL_ON      = 8'hFF;
    localparam logic [7:0]  FULL_OFF     = 8'h00;
    localparam logic [13:0] WIDTH_BASE   = 14'd640;

    typedef struct packed {
        logic [3:0]  chan;
        logic [15:0] etime;
    } edge_entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        edge_entry_t      wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] rp;
    } seq_status_t;

    // pulse width in us: 640 + 4b + ((b/2)*b)/4, at most 9756 (9720 for b up to 254)
    function automatic logic [13:0] pulse_width(input logic [7:0] b);
        logic [14:0] prod;
        prod = {8'b0, b[7:1]} * {7'b0, b};
        return WIDTH_BASE + {4'b0, b, 2'b0} + 14'(prod >> 2);
    endfunction

    function automatic logic [15:0] chan_bit(input logic [3:0] c);
        return 16'(1) << c;
    endfunction

endpackage

// ===== sv/sep_if.sv =====
// valid/ready channel interfaces for requests and results
// depends on sep_pkg
interface sep_req_if;
    import sep_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [3:0] channel;
    logic [7:0] brightness;

    modport source (output valid, output req_type, output channel, output brightness,
                    input ready);
    modport sink   (input valid, input req_type, input channel, input brightness,
                    output ready);
endinterface

interface sep_rsp_if;
    import sep_pkg::*;
    logic        valid;
    logic        ready;
    logic [15:0] levels;
    logic [15:0] edge_time;

    modport source (output valid, output levels, output edge_time, input ready);
    modport sink   (input valid, input levels, input edge_time, output ready);
endinterface

// ===== sv/sep_apb_cfg.sv =====
// apb-style configuration register holding the pwm period
// depends on sep_pkg
module sep_apb_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sep_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [15:0]                period
);
    import sep_pkg::*;

    logic [15:0] period_reg;
    logic [15:0] period_next;
    logic        wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_PERIOD);

    always_comb
    begin
        period_next = period_reg;
        if (wr_hit)
        begin
            period_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else
        begin
            period_reg <= period_next;
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_PERIOD) ? {16'b0, period_reg} : 32'b0;
    assign period = period_reg;

endmodule

// ===== sv/sep_edge_mem.sv =====
// edge table ram: one write port, one read port, registered read data
// depends on sep_pkg
module sep_edge_mem (
    input  logic                 clk,
    input  sep_pkg::mem_req_t    mem_req,
    output sep_pkg::edge_entry_t rd_data
);
    import sep_pkg::*;

    edge_entry_t edge_mem [EDGE_DEPTH];
    edge_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            edge_mem[mem_req.waddr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rd_data_reg <= edge_mem[mem_req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/sep_seq.sv =====
// request sequencer: scans and shifts the edge table, pops edges, holds the result register
// depends on sep_pkg and sep_if
module sep_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [15:0]            period,
    sep_req_if.sink                req,
    sep_rsp_if.source              rsp,
    output sep_pkg::mem_req_t      mem_req,
    input  sep_pkg::edge_entry_t   rd_data,
    output sep_pkg::seq_status_t   stat
);
    import sep_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_NE_FIRST = 4'd1;
    localparam logic [3:0] ST_NE_NEXT  = 4'd2;
    localparam logic [3:0] ST_PREP     = 4'd3;
    localparam logic [3:0] ST_SCAN     = 4'd4;
    localparam logic [3:0] ST_DROP     = 4'd5;
    localparam logic [3:0] ST_SHDN     = 4'd6;
    localparam logic [3:0] ST_INS      = 4'd7;
    localparam logic [3:0] ST_SHUP     = 4'd8;
    localparam logic [3:0] ST_WRNEW    = 4'd9;
    localparam logic [3:0] ST_DONE     = 4'd10;

    // control state
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rp_reg, rp_next;
    logic [15:0]      start_reg, start_next;
    logic [15:0]      lev_reg, lev_next;
    logic [15:0]      time_reg, time_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // working payload
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] d_reg, d_next;
    logic             found_reg, found_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [3:0]       ch_reg, ch_next;
    logic [7:0]       b_reg, b_next;
    logic [13:0]      w_reg, w_next;
    logic [15:0]      tnew_reg, tnew_next;
    logic             ins_reg, ins_next;
    logic [15:0]      rsp_lev_reg, rsp_lev_next;
    logic [15:0]      rsp_time_reg, rsp_time_next;

    logic [CNT_W-1:0] rp_inc;
    logic [CNT_W-1:0] cnt_dec;
    logic [CNT_W-1:0] idx_ext;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] d_ext;
    logic [15:0]      ch_mask;

    assign rp_inc  = rp_reg + CNT_W'(1);
    assign cnt_dec = cnt_reg - CNT_W'(1);
    assign idx_ext = CNT_W'(idx_reg);
    assign idx_inc = idx_ext + CNT_W'(1);
    assign d_ext   = CNT_W'(d_reg);
    assign ch_mask = chan_bit(ch_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rp_next        = rp_reg;
        start_next     = start_reg;
        lev_next       = lev_reg;
        time_next      = time_reg;
        idx_next       = idx_reg;
        d_next         = d_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        ch_next        = ch_reg;
        b_next         = b_reg;
        w_next         = w_reg;
        tnew_next      = tnew_reg;
        ins_next       = ins_reg;
        rsp_lev_next   = rsp_lev_reg;
        rsp_time_next  = rsp_time_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        mem_req        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.req_type)
                        REQ_START:
                        begin
                            lev_next   = start_reg;
                            time_next  = 16'd0;
                            rp_next    = '0;
                            state_next = ST_DONE;
                        end
                        REQ_NEXT:
                        begin
                            if (rp_reg >= cnt_reg)
                            begin
                                time_next  = NO_EDGE;
                                lev_next   = 16'd0;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = rp_reg[IDX_W-1:0];
                                state_next    = ST_NE_FIRST;
                            end
                        end
                        REQ_SET:
                        begin
                            if ({1'b0, req.channel} < 5'(CHANNELS))
                            begin
                                ch_next    = req.channel;
                                b_next     = req.brightness;
                                w_next     = pulse_width(req.brightness);
                                state_next = ST_PREP;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // first popped edge fixes the time of this group
            ST_NE_FIRST:
            begin
                time_next = rd_data.etime;
                lev_next  = lev_reg ^ chan_bit(rd_data.chan);
                rp_next   = rp_inc;
                if (rp_inc < cnt_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = rp_inc[IDX_W-1:0];
                    state_next    = ST_NE_NEXT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_NE_NEXT:
            begin
                if (rd_data.etime == time_reg)
                begin
                    lev_next = lev_reg ^ chan_bit(rd_data.chan);
                    rp_next  = rp_inc;
                    if (rp_inc < cnt_reg)
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = rp_inc[IDX_W-1:0];
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            // start level from the brightness, edge time from the pulse width
            ST_PREP:
            begin
                found_next = 1'b0;
                pos_next   = '0;
                idx_next   = '0;
                ins_next   = 1'b0;
                if (b_reg == FULL_ON)
                begin
                    start_next = start_reg | ch_mask;
                end
                else if (b_reg == FULL_OFF)
                begin
                    start_next = start_reg & ~ch_mask;
                end
                else
                begin
                    ins_next = 1'b1;
                    if ({2'b0, w_reg} > {1'b0, period[15:1]})
                    begin
                        start_next = start_reg | ch_mask;
                        tnew_next  = {2'b0, w_reg};
                    end
                    else
                    begin
                        start_next = start_reg & ~ch_mask;
                        tnew_next  = period - {2'b0, w_reg};
                    end
                end
                if (cnt_reg != '0)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = '0;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DROP;
                end
            end

            // one pass finds the old entry and the insert slot after its removal
            ST_SCAN:
            begin
                if (rd_data.chan == ch_reg)
                begin
                    found_next = 1'b1;
                    d_next     = idx_reg;
                end
                else if (rd_data.etime <= tnew_reg)
                begin
                    pos_next = pos_reg + CNT_W'(1);
                end
                if (idx_inc < cnt_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_inc[IDX_W-1:0];
                    idx_next      = idx_inc[IDX_W-1:0];
                end
                else
                begin
                    state_next = ST_DROP;
                end
            end

            ST_DROP:
            begin
                state_next = ST_INS;
                if (found_reg)
                begin
                    cnt_next = cnt_dec;
                    if (rp_reg > cnt_dec)
                    begin
                        rp_next = cnt_dec;
                    end
                    if (d_ext < cnt_dec)
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = d_reg + IDX_W'(1);
                        idx_next      = d_reg + IDX_W'(1);
                        state_next    = ST_SHDN;
                    end
                end
            end

            // close the gap: entry idx moves to idx-1, cnt_reg already reduced
            ST_SHDN:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg - IDX_W'(1);
                mem_req.wdata = rd_data;
                if (idx_ext < cnt_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_inc[IDX_W-1:0];
                    idx_next      = idx_inc[IDX_W-1:0];
                end
                else
                begin
                    state_next = ST_INS;
                end
            end

            ST_INS:
            begin
                if (ins_reg && (cnt_reg < CNT_W'(EDGE_DEPTH)))
                begin
                    if (cnt_reg > pos_reg)
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = cnt_dec[IDX_W-1:0];
                        idx_next      = cnt_dec[IDX_W-1:0];
                        state_next    = ST_SHUP;
                    end
                    else
                    begin
                        state_next = ST_WRNEW;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            // open the slot from the top down: entry idx moves to idx+1
            ST_SHUP:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg + IDX_W'(1);
                mem_req.wdata = rd_data;
                if (idx_ext > pos_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_reg - IDX_W'(1);
                    idx_next      = idx_reg - IDX_W'(1);
                end
                else
                begin
                    state_next = ST_WRNEW;
                end
            end

            ST_WRNEW:
            begin
                mem_req.we          = 1'b1;
                mem_req.waddr       = pos_reg[IDX_W-1:0];
                mem_req.wdata.chan  = ch_reg;
                mem_req.wdata.etime = tnew_reg;
                cnt_next            = cnt_reg + CNT_W'(1);
                state_next          = ST_DONE;
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_lev_next   = lev_reg;
                    rsp_time_next  = time_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rp_reg        <= '0;
            start_reg     <= '0;
            lev_reg       <= '0;
            time_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rp_reg        <= rp_next;
            start_reg     <= start_next;
            lev_reg       <= lev_next;
            time_reg      <= time_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        d_reg        <= d_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        ch_reg       <= ch_next;
        b_reg        <= b_next;
        w_reg        <= w_next;
        tnew_reg     <= tnew_next;
        ins_reg      <= ins_next;
        rsp_lev_reg  <= rsp_lev_next;
        rsp_time_reg <= rsp_time_next;
    end

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.levels    = rsp_lev_reg;
    assign rsp.edge_time = rsp_time_reg;

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.cnt  = cnt_reg;
    assign stat.rp   = rp_reg;

endmodule

// ===== sv/sorted_edge_pwm_scheduler.sv =====
// top level of the sorted edge pwm scheduler
// depends on sep_pkg, sep_if, sep_apb_cfg, sep_edge_mem, sep_seq
//
//  port      dir   kind              transfer when
//  req       in    valid/ready       req.valid && req.ready
//  rsp       out   valid/ready       rsp.valid && rsp.ready
//  apb       in    psel/penable      psel && penable && pwrite (pready tied high)
//
// one request at a time; each gives one result, held in an output register so the
// next request is taken while the result waits. next edge pops every edge that
// shares the earliest remaining time; set duty scans the table for the channel's
// old edge and the insert slot, closes the gap, opens the slot and writes the new
// edge, the table ram's one read and one write port walking the sorted table one
// entry per cycle.
// no clearing pass after reset: only entries below the edge count are ever read.
// a stalled result holds the sequencer in its final state until the transfer.
module sorted_edge_pwm_scheduler (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sep_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    sep_req_if.sink                    req,
    sep_rsp_if.source                  rsp
);
    import sep_pkg::*;

    logic [15:0] period;
    mem_req_t    mem_req;     // sequencer to table ram
    edge_entry_t rd_data;     // registered ram read data, valid in the cycle after the read
    seq_status_t stat;

    // period register behind the apb port
    sep_apb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .period  (period)
    );

    // sorted edge table, channel and time per entry
    sep_edge_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // read-modify-write sequencer; shifts read one neighbor while writing the other,
    // so a read and a write never hit the same entry in the same cycle
    sep_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .period  (period),
        .req     (req),
        .rsp     (rsp),
        .mem_req (mem_req),
        .rd_data (rd_data),
        .stat    (stat)
    );

    // table never overfills
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.cnt <= CNT_W'(EDGE_DEPTH))
        else $error("edge count above table depth");

    // read pointer stays within the filled part of the table
    a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.rp <= stat.cnt)
        else $error("read pointer beyond edge count");

    // an accepted request is either being worked on or already has its result
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (stat.busy || rsp.valid))
        else $error("accepted request left no work and no result");

    // shifts never read and write one entry in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && mem_req.re && (mem_req.waddr == mem_req.raddr)))
        else $error("table read and write collide");

endmodule

// ===== test/sorted_edge_pwm_scheduler_tb.sv =====
// testbench for sorted_edge_pwm_scheduler: random and directed requests checked against
// an in-bench schedule predictor, with random stalls on both channels and apb period writes
// depends on sep_pkg, sep_if and the scheduler rtl
`timescale 1ns / 100ps

module sorted_edge_pwm_scheduler_tb;
    import sep_pkg::*;

    // request code the block leaves unused
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // longer than the worst set duty, so this covers any leftover work
    localparam int SETTLE_CYCLES = 60;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam logic [ADDR_W-1:0] PERIOD_ADDR = ADDR_W'({REG_PERIOD, 2'b00});

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] channel;
        logic [7:0] brightness;
    } sched_req_t;

    typedef struct packed {
        logic [15:0] levels;
        logic [15:0] edge_time;
    } sched_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sep_req_if req_ch ();
    sep_rsp_if rsp_ch ();

    sorted_edge_pwm_scheduler u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // ------------------------------------------------------------------
    // schedule predictor: sorted edge list, start and running levels
    // ------------------------------------------------------------------
    logic [15:0] sched_period;
    logic [3:0]  edge_chan [EDGE_DEPTH];
    logic [15:0] edge_at   [EDGE_DEPTH];
    int          edge_total;
    int          next_slot;
    logic [15:0] level_start;
    logic [15:0] level_now;
    logic [15:0] time_now;

    // take a channel's edge out of the list, pulling the read slot back if needed
    function automatic void drop_channel(input logic [3:0] ch);
        for (int i = 0; i < edge_total; i++)
        begin
            if (edge_chan[i] == ch)
            begin
                for (int j = i; j < edge_total - 1; j++)
                begin
                    edge_chan[j] = edge_chan[j + 1];
                    edge_at[j]   = edge_at[j + 1];
                end
                edge_total--;
                if (next_slot > edge_total)
                    next_slot = edge_total;
                return;
            end
        end
    endfunction

    // sorted insert; equal times keep arrival order
    function automatic void place_channel(input logic [3:0] ch, input logic [15:0] t);
        int pos;
        pos = 0;
        drop_channel(ch);
        if (edge_total >= EDGE_DEPTH)
            return;
        while (pos < edge_total && edge_at[pos] <= t)
            pos++;
        for (int j = edge_total; j > pos; j--)
        begin
            edge_chan[j] = edge_chan[j - 1];
            edge_at[j]   = edge_at[j - 1];
        end
        edge_chan[pos] = ch;
        edge_at[pos]   = t;
        edge_total++;
    endfunction

    function automatic void set_channel_duty(input logic [3:0] ch, input logic [7:0] b);
        logic [15:0] mask;
        int bi;
        int w;
        if (int'(ch) >= CHANNELS)
            return;
        mask = 16'(1) << ch;
        bi = int'(b);
        if (b == FULL_ON)
        begin
            level_start = level_start | mask;
            drop_channel(ch);
        end
        else if (b == FULL_OFF)
        begin
            level_start = level_start & ~mask;
            drop_channel(ch);
        end
        else
        begin
            w = int'(WIDTH_BASE) + 4 * bi + ((bi / 2) * bi) / 4;
            // long pulses start high and fall at w, short ones rise late in the period
            if (w > int'(sched_period) / 2)
            begin
                level_start = level_start | mask;
                place_channel(ch, 16'(w));
            end
            else
            begin
                level_start = level_start & ~mask;
                place_channel(ch, 16'(int'(sched_period) - w));
            end
        end
    endfunction

    // pop every edge that shares the earliest remaining time
    function automatic void pop_edges();
        logic [15:0] t;
        if (next_slot >= edge_total)
        begin
            time_now  = NO_EDGE;
            level_now = '0;
            return;
        end
        t = edge_at[next_slot];
        while (next_slot < edge_total && edge_at[next_slot] == t)
        begin
            level_now = level_now ^ (16'(1) << edge_chan[next_slot]);
            next_slot++;
        end
        time_now = t;
    endfunction

    function automatic sched_rsp_t advance_schedule(input sched_req_t r);
        sched_rsp_t res;
        case (r.req_type)
            REQ_SET:   set_channel_duty(r.channel, r.brightness);
            REQ_START:
            begin
                time_now  = '0;
                level_now = level_start;
                next_slot = 0;
            end
            REQ_NEXT:  pop_edges();
            default:   ;
        endcase
        res.levels    = level_now;
        res.edge_time = time_now;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // bookkeeping shared between stimulus, driver and monitor
    // ------------------------------------------------------------------
    sched_req_t pending_reqs [$];
    sched_rsp_t expected_rsps [$];
    int         reqs_issued;
    int         reqs_accepted;
    int         error_count;
    logic       req_taken;
    logic       idle_on;
    logic       pressure_on;
    logic       long_stall;
    int         send_gap;
    int         ready_gap;
    int         long_hold_count;

    // clock, 2 ns period
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // request driver: presents the next pending item at the falling edge
    // once the previous one has made its transfer
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : req_driver
        sched_req_t item;
        if (!req_ch.valid || req_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                if (idle_on && $urandom_range(0, 5) == 0)
                begin
                    // random idle gap before the next item, counting this one
                    send_gap = $urandom_range(0, 6);
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    item = pending_reqs.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.req_type   <= item.req_type;
                    req_ch.channel    <= item.channel;
                    req_ch.brightness <= item.brightness;
                end
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result receiver: random stall bursts, plus the long hold-off
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : rsp_driver
        if (ready_gap > 0)
        begin
            ready_gap--;
            rsp_ch.ready <= 1'b0;
        end
        else if (long_stall)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            ready_gap = $urandom_range(0, 6);
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // long hold-off on the result side so the block backs up and stalls its input
    always @(posedge clk)
    begin : long_hold
        if (pressure_on && long_hold_count < LONG_HOLD_CYCLES)
        begin
            long_hold_count <= long_hold_count + 1;
            long_stall      <= 1'b1;
        end
        else
        begin
            long_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result transfer, then predicts for each request transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        sched_req_t got_req;
        sched_rsp_t want;
        if (!rst_n)
        begin
            req_taken <= 1'b0;
        end
        else
        begin
            req_taken <= req_ch.valid && req_ch.ready;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected result levels %h edge_time %h", $time,
                             rsp_ch.levels, rsp_ch.edge_time);
                    error_count++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp_ch.levels !== want.levels)
                    begin
                        $display("%0t: levels expected %h actual %h", $time,
                                 want.levels, rsp_ch.levels);
                        error_count++;
                    end
                    if (rsp_ch.edge_time !== want.edge_time)
                    begin
                        $display("%0t: edge_time expected %h actual %h", $time,
                                 want.edge_time, rsp_ch.edge_time);
                        error_count++;
                    end
                end
            end
            // a result never leaves in the same cycle as its own request, so predict last
            if (req_ch.valid && req_ch.ready)
            begin
                got_req.req_type   = req_ch.req_type;
                got_req.channel    = req_ch.channel;
                got_req.brightness = req_ch.brightness;
                expected_rsps.push_back(advance_schedule(got_req));
                reqs_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_req(input logic [1:0] rt, input logic [3:0] ch, input logic [7:0] b);
        sched_req_t item;
        item.req_type   = rt;
        item.channel    = ch;
        item.brightness = b;
        pending_reqs.push_back(item);
        reqs_issued++;
    endtask

    // wait until every request has made its transfer and every result has come back
    task automatic wait_drained();
        while (reqs_accepted != reqs_issued || expected_rsps.size() != 0)
            @(negedge clk);
    endtask

    // apb write then read-back of the period register, only while the block is idle
    task automatic write_period(input logic [15:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PERIOD_ADDR;
        pwdata  = {16'b0, value};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        sched_period = value;
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata[15:0] !== sched_period)
        begin
            $display("%0t: period_us read expected %h actual %h", $time,
                     sched_period, prdata[15:0]);
            error_count++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // brightness mix: off, fully on, the map's ends, the previous value, or anything in between
    function automatic logic [7:0] pick_brightness(input logic [7:0] prev);
        case ($urandom_range(0, 9))
            0:       return FULL_OFF;
            1:       return FULL_ON;
            2:       return 8'd1;
            3:       return 8'd254;
            4:       return prev;     // same width on another channel gives equal times
            default: return 8'($urandom_range(1, 254));
        endcase
    endfunction

    // one pwm period: a few duty changes, a period start, then a run of next-edge
    // requests that usually walks off the end of the table; some noise mixed in
    task automatic one_period(output int made);
        int n_set;
        int n_next;
        logic [7:0] b;
        made  = 0;
        b     = 8'($urandom_range(1, 254));
        n_set = $urandom_range(0, 4);
        for (int i = 0; i < n_set; i++)
        begin
            b = pick_brightness(b);
            push_req(REQ_SET, 4'($urandom_range(0, 15)), b);
            made++;
        end
        // now and then leave out the period start to break the sequence
        if ($urandom_range(0, 7) != 0)
        begin
            push_req(REQ_START, 4'($urandom), 8'($urandom));
            made++;
        end
        n_next = $urandom_range(1, 18);
        for (int i = 0; i < n_next; i++)
        begin
            case ($urandom_range(0, 11))
                0:
                begin
                    // duty change in mid period
                    b = pick_brightness(b);
                    push_req(REQ_SET, 4'($urandom_range(0, 15)), b);
                    made++;
                end
                1:
                begin
                    push_req(REQ_UNUSED, 4'($urandom), 8'($urandom));
                    made++;
                end
                default: ;
            endcase
            push_req(REQ_NEXT, 4'($urandom), 8'($urandom));
            made++;
        end
    endtask

    task automatic random_phase(input int target);
        int made;
        int total;
        total = 0;
        while (total < target)
        begin
            one_period(made);
            total += made;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_SET;
        req_ch.channel    = '0;
        req_ch.brightness = '0;
        rsp_ch.ready      = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        reqs_issued     = 0;
        reqs_accepted   = 0;
        error_count     = 0;
        send_gap        = 0;
        ready_gap       = 0;
        long_hold_count = 0;
        idle_on         = 1'b1;
        pressure_on     = 1'b0;
        long_stall      = 1'b0;
        // predictor reset state
        sched_period = PERIOD_RESET;
        edge_total   = 0;
        next_slot    = 0;
        level_start  = '0;
        level_now    = '0;
        time_now     = '0;
        for (int i = 0; i < EDGE_DEPTH; i++)
        begin
            edge_chan[i] = '0;
            edge_at[i]   = '0;
        end

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at the reset period
        push_req(REQ_NEXT, 4'd0, 8'd0);          // empty table reports no edge
        push_req(REQ_UNUSED, 4'd9, 8'hA5);       // unused code changes nothing
        push_req(REQ_START, 4'd15, 8'hFF);       // start with nothing set
        push_req(REQ_SET, 4'd0, 8'd1);           // shortest pulse, rises late
        push_req(REQ_SET, 4'd15, 8'd254);        // longest pulse, starts high
        push_req(REQ_SET, 4'd3, FULL_ON);
        push_req(REQ_SET, 4'd4, FULL_OFF);
        push_req(REQ_SET, 4'd5, 8'd1);           // ties with channel 0
        push_req(REQ_SET, 4'd7, 8'd128);
        push_req(REQ_START, 4'd0, 8'd0);
        push_req(REQ_NEXT, 4'd0, 8'd0);
        push_req(REQ_NEXT, 4'd12, 8'd77);        // pops both tied edges
        push_req(REQ_NEXT, 4'd0, 8'd0);
        push_req(REQ_NEXT, 4'd0, 8'd0);          // past the end
        push_req(REQ_START, 4'd0, 8'd0);
        push_req(REQ_NEXT, 4'd0, 8'd0);
        push_req(REQ_SET, 4'd0, 8'd200);         // replace an edge in mid period
        push_req(REQ_SET, 4'd15, FULL_OFF);      // table shrinks under the read slot
        push_req(REQ_SET, 4'd7, FULL_ON);
        push_req(REQ_NEXT, 4'd0, 8'd0);
        push_req(REQ_NEXT, 4'd0, 8'd0);
        push_req(REQ_START, 4'd0, 8'd0);
        push_req(REQ_NEXT, 4'd0, 8'd0);
        push_req(REQ_UNUSED, 4'd15, 8'hFF);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        // shortest period: more pulses start high than at any longer period
        write_period(16'd9756);
        random_phase(100);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        // longest period, with the result side held off for a long stretch
        write_period(16'd65534);
        pressure_on = 1'b1;
        random_phase(100);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        write_period(16'($urandom_range(9757, 65533)));
        random_phase(100);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        // last part back at the reset period, no idling on either side
        write_period(PERIOD_RESET);
        idle_on = 1'b0;
        random_phase(100);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0 && expected_rsps.size() == 0)
            $display("sorted_edge_pwm_scheduler_tb passed");
        else
            $display("sorted_edge_pwm_scheduler_tb failed");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin : watchdog
        #1000000;
        $display("sorted_edge_pwm_scheduler_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sep_pkg.sv
sv/sep_if.sv
sv/sep_apb_cfg.sv
sv/sep_edge_mem.sv
sv/sep_seq.sv
sv/sorted_edge_pwm_scheduler.sv
test/sorted_edge_pwm_scheduler_tb.sv
